>>> rtl/dqr_pkg.sv
// shared types and constants for the deque with reverse
package dqr_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_POP_BACK   = 3'd0,
    MODE_POP_FRONT  = 3'd1,
    MODE_REVERSE    = 3'd2,
    MODE_PUSH_BACK  = 3'd3,
    MODE_PUSH_FRONT = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_POPPED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    flip;
    logic    front;
    logic    err_valid;
    status_e err_code;
    logic    capture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rsp_busy;
  } sts_t;

endpackage

>>> rtl/dqr_cmd_if.sv
// command channel: operation code and value to push
interface dqr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [dqr_pkg::MODE_W-1:0]          mode;
  logic signed [dqr_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

>>> rtl/dqr_rsp_if.sv
// response channel: popped value and status
interface dqr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [dqr_pkg::DATA_W-1:0]   popped_value;
  logic [dqr_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output popped_value, output status, input ready);
  modport sink   (input valid, input popped_value, input status, output ready);
endinterface

>>> rtl/dqr_ram.sv
// generic simple dual-port ram with registered read
module dqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dqr_ctrl.sv
// controller: decodes the operation and sequences the ram read of a pop
module dqr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dqr_pkg::MODE_W-1:0] mode_i,
  input  dqr_pkg::sts_t              sts_i,
  output dqr_pkg::cmd_t              cmd_o
);

  dqr_pkg::state_e state_q, state_d;
  logic            fire;
  logic            pop_go;

  assign in_ready_o = (state_q == dqr_pkg::S_IDLE) && !sts_i.rsp_busy;
  assign fire       = in_valid_i && in_ready_o;

  // a pop of a non-empty queue goes on to wait for the ram
  always_comb begin
    pop_go = 1'b0;
    unique case (dqr_pkg::mode_e'(mode_i)) inside
      dqr_pkg::MODE_POP_BACK,
      dqr_pkg::MODE_POP_FRONT: pop_go = !sts_i.empty;
      default:                 pop_go = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dqr_pkg::S_IDLE: begin
        if (fire && pop_go) begin
          state_d = dqr_pkg::S_READ;
        end
      end
      dqr_pkg::S_READ: state_d = dqr_pkg::S_IDLE;
      default:         state_d = dqr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.err_code = dqr_pkg::ST_POPPED;
    unique case (state_q)
      dqr_pkg::S_IDLE: begin
        if (fire) begin
          unique case (dqr_pkg::mode_e'(mode_i)) inside
            dqr_pkg::MODE_POP_BACK,
            dqr_pkg::MODE_POP_FRONT: begin
              cmd_o.front = (mode_i == dqr_pkg::MODE_POP_FRONT);
              if (sts_i.empty) begin
                cmd_o.err_valid = 1'b1;
                cmd_o.err_code  = dqr_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            dqr_pkg::MODE_REVERSE: cmd_o.flip = 1'b1;
            dqr_pkg::MODE_PUSH_BACK,
            dqr_pkg::MODE_PUSH_FRONT: begin
              cmd_o.front = (mode_i == dqr_pkg::MODE_PUSH_FRONT);
              if (sts_i.full) begin
                cmd_o.err_valid = 1'b1;
                cmd_o.err_code  = dqr_pkg::ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            default: ; // unused codes are consumed with no effect
          endcase
        end
      end
      dqr_pkg::S_READ: cmd_o.capture = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/dqr_dp.sv
// datapath: head pointer, count, direction flag, element ram, output register
module dqr_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [dqr_pkg::DATA_W-1:0]  value_i,
  input  dqr_pkg::cmd_t                      cmd_i,
  output dqr_pkg::sts_t                      sts_o,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output logic signed [dqr_pkg::DATA_W-1:0]  popped_value_o,
  output logic [dqr_pkg::STATUS_W-1:0]       status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = AW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [dqr_pkg::DATA_W-1:0] out_value_q, out_value_d;
  dqr_pkg::status_e                  out_status_q, out_status_d;

  logic          phys_front;
  logic [AW-1:0] head_inc, head_dec;
  logic [PW-1:0] tail_sum, back_sum;
  logic [AW-1:0] tail_idx, back_idx;
  logic [AW-1:0] waddr, raddr;
  logic [dqr_pkg::DATA_W-1:0] rdata;

  assign phys_front = cmd_i.front ^ rev_q;

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  // sums stay below twice the depth, so one conditional subtract wraps them
  assign tail_sum = {1'b0, head_q} + PW'(count_q);
  assign back_sum = tail_sum - PW'(1);
  assign tail_idx = (tail_sum >= PW'(DEPTH)) ? AW'(tail_sum - PW'(DEPTH)) : AW'(tail_sum);
  assign back_idx = (back_sum >= PW'(DEPTH)) ? AW'(back_sum - PW'(DEPTH)) : AW'(back_sum);

  assign waddr = phys_front ? head_dec : tail_idx;
  assign raddr = phys_front ? head_q : back_idx;

  dqr_ram #(
    .WIDTH (dqr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (cmd_i.pop),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rev_d   = rev_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      if (phys_front) begin
        head_d = head_dec;
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      if (phys_front) begin
        head_d = head_inc;
      end
    end else if (cmd_i.flip) begin
      rev_d = !rev_q;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !rsp_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (cmd_i.err_valid) begin
      out_valid_d  = 1'b1;
      out_value_d  = '0;
      out_status_d = cmd_i.err_code;
    end else if (cmd_i.capture) begin
      out_valid_d  = 1'b1;
      out_value_d  = rdata;
      out_status_d = dqr_pkg::ST_POPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.rsp_busy = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

>>> rtl/deque_with_reverse.sv
// top level of the double-ended queue with constant-time reverse
//
//   channel  dir  payload                       handshake
//   cmd_i    in   mode[2:0], value[31:0]        valid/ready
//   rsp_o    out  popped_value[31:0], status    valid/ready
//
// push, reverse, unused codes and failed pops or pushes keep the controller idle;
// a successful pop blocks new items while the ram's registered read is under way.
// the response register holds one item; a new item is taken while it drains.
// reset clears head, count and direction; the element ram needs no clearing.
// a stalled response blocks further items until it is taken.
module deque_with_reverse #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dqr_cmd_if.sink         cmd_i,
  dqr_rsp_if.source       rsp_o
);

  dqr_pkg::cmd_t cmd;
  dqr_pkg::sts_t sts;

  dqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .mode_i     (cmd_i.mode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (cmd_i.value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .popped_value_o (rsp_o.popped_value),
    .status_o       (rsp_o.status)
  );

  // at most one action per cycle reaches the datapath
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.push, cmd.pop, cmd.flip, cmd.err_valid, cmd.capture}))
    else $error("more than one datapath action in a cycle");

  // an error item only when the queue really is empty or full
  a_err_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.err_valid |-> (sts.empty || sts.full))
    else $error("error response with queue neither empty nor full");

  // read data is captured in the cycle after a pop reads the ram
  a_capture_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> cmd.capture)
    else $error("pop not followed by capture");

  // a pop never leaves the response register stalled when its data lands
  a_capture_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !sts.rsp_busy)
    else $error("capture into a busy response register");

endmodule

>>> tb/sv/dqr_checker.sv
// checker for the deque: predicts responses from accepted commands and compares them
module dqr_checker #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dqr_cmd_if          cmd_i,
  dqr_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned empty_count_o,
  output int unsigned full_count_o
);
  import dqr_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } rsp_t;

  // shadow copy of the deque
  logic [DATA_W-1:0] elem_mem [DEPTH];
  int unsigned       head_idx = 0;
  int unsigned       fill     = 0;
  logic              flipped  = 1'b0;

  rsp_t        rsp_expected_q [$];
  int unsigned fails   = 0;
  int unsigned pending = 0;
  int unsigned checked = 0;
  int unsigned empties = 0;
  int unsigned fulls   = 0;

  assign fail_count_o  = fails;
  assign pending_o     = pending;
  assign checked_o     = checked;
  assign empty_count_o = empties;
  assign full_count_o  = fulls;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task automatic expect_rsp(input logic [DATA_W-1:0] value, input status_e status);
    rsp_t want;
    want.value  = value;
    want.status = status;
    rsp_expected_q = {rsp_expected_q, want};
  endtask

  task automatic predict_cmd(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    logic phys_front;
    case (mode) inside
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (fill == 0) begin
          expect_rsp('0, ST_EMPTY);
          empties++;
        end else begin
          // reversed direction swaps which physical end is the logical front
          phys_front = (mode == MODE_POP_FRONT) ^ flipped;
          if (phys_front) begin
            expect_rsp(elem_mem[head_idx], ST_POPPED);
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            expect_rsp(elem_mem[(head_idx + fill - 1) % DEPTH], ST_POPPED);
          end
          fill--;
        end
      end
      MODE_REVERSE: flipped = ~flipped;
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          expect_rsp('0, ST_FULL);
          fulls++;
        end else begin
          phys_front = (mode == MODE_PUSH_FRONT) ^ flipped;
          if (phys_front) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            elem_mem[head_idx] = value;
          end else begin
            elem_mem[(head_idx + fill) % DEPTH] = value;
          end
          fill++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_rsp();
    rsp_t want;
    if (rsp_expected_q.size() == 0) begin
      report($sformatf("response with nothing expected: value %0d status %0d",
                       $signed(rsp_i.popped_value), rsp_i.status));
      return;
    end
    want = rsp_expected_q.pop_front();
    checked++;
    if (rsp_i.popped_value !== want.value)
      report($sformatf("popped_value %0d, expected %0d",
                       $signed(rsp_i.popped_value), want.value));
    if (rsp_i.status !== want.status)
      report($sformatf("status %0d, expected %0d", rsp_i.status, want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = 0;
      fill     = 0;
      flipped  = 1'b0;
      rsp_expected_q.delete();
      pending  = 0;
    end else begin
      // a response never belongs to the command taken at the same edge
      if (rsp_i.valid && rsp_i.ready) check_rsp();
      if (cmd_i.valid && cmd_i.ready) predict_cmd(cmd_i.mode, cmd_i.value);
      pending = rsp_expected_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// testbench top for the deque with reverse: stimulus, response stalls and verdict
module tb;
  import dqr_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_CHOPPY
  } rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dqr_cmd_if cmd ();
  dqr_rsp_if rsp ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned empty_count;
  int unsigned full_count;

  deque_with_reverse #(.DEPTH(DEPTH)) uut (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  dqr_checker #(.DEPTH(DEPTH)) chk (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .rsp_i         (rsp),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .empty_count_o (empty_count),
    .full_count_o  (full_count)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // response side stalls, style changes every so often
  rx_style_e   rx_style = RX_OPEN;
  int unsigned rx_cycle = 0;
  int unsigned rx_hold  = 0;

  always @(posedge clk_i) begin
    if (rx_cycle % 192 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_style)
      RX_OPEN:   rsp.ready <= 1'b1;
      RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp.ready <= (rx_cycle % 5 == 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold--;
          rsp.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_hold = $urandom_range(3, 15);
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    endcase
  end

  // stimulus bookkeeping
  int unsigned burst_left = 0;
  int unsigned level      = 0;
  int unsigned n_push     = 0;
  int unsigned n_pop      = 0;
  int unsigned n_rev      = 0;
  int unsigned n_spare    = 0;

  // drive one item in bursts with random gaps, return after the edge that takes it
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.mode  <= mode;
    cmd.value <= value;
    do begin
      @(negedge clk_i);
      taken = cmd.ready;
      @(posedge clk_i);
    end while (!taken);
    case (mode) inside
      MODE_POP_BACK, MODE_POP_FRONT: begin
        n_pop++;
        if (level != 0) level--;
      end
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        n_push++;
        if (level < DEPTH) level++;
      end
      MODE_REVERSE: n_rev++;
      default: n_spare++;
    endcase
  endtask

  // weighted random operations; with until_full it runs until the deque is full
  task automatic run_random(input int unsigned count, input int unsigned push_w,
                            input int unsigned pop_w, input int unsigned rev_w,
                            input bit until_full);
    int unsigned       n;
    int unsigned       r;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    n = 0;
    while (until_full ? (level < DEPTH) : (n < count)) begin
      r = $urandom_range(0, 99);
      if (r < push_w)
        mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else if (r < push_w + pop_w)
        mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      else if (r < push_w + pop_w + rev_w)
        mode = MODE_REVERSE;
      else
        mode = MODE_SPARE_LO
             + MODE_W'($urandom_range(0, MODE_SPARE_HI - MODE_SPARE_LO));
      case ($urandom_range(0, 15))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom();
      endcase
      send_cmd(mode, value);
      n++;
    end
  endtask

  initial begin
    int unsigned drain;
    cmd.valid <= 1'b0;
    cmd.mode  <= MODE_REVERSE;
    cmd.value <= '0;
    rst_ni    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, extreme values at both ends, reverse, spare codes
    send_cmd(MODE_POP_BACK,   32'h0);
    send_cmd(MODE_POP_FRONT,  32'h1234_5678);
    send_cmd(MODE_PUSH_BACK,  32'h7fff_ffff);
    send_cmd(MODE_PUSH_FRONT, 32'h8000_0000);
    send_cmd(MODE_PUSH_BACK,  32'h0);
    send_cmd(MODE_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(MODE_POP_FRONT,  32'h0);
    send_cmd(MODE_POP_BACK,   32'h0);
    send_cmd(MODE_REVERSE,    32'hffff_ffff);
    send_cmd(MODE_POP_FRONT,  32'h0);
    send_cmd(MODE_PUSH_FRONT, 32'h5555_5555);
    send_cmd(MODE_PUSH_BACK,  32'haaaa_aaaa);
    send_cmd(MODE_SPARE_LO,   32'hffff_ffff);
    send_cmd(MODE_SPARE_LO + 3'd1, 32'h0);
    send_cmd(MODE_SPARE_HI,   32'hffff_ffff);
    send_cmd(MODE_POP_BACK,   32'h0);
    send_cmd(MODE_REVERSE,    32'h0);
    send_cmd(MODE_REVERSE,    32'h0);
    send_cmd(MODE_POP_FRONT,  32'h0);
    send_cmd(MODE_POP_BACK,   32'h0);
    send_cmd(MODE_POP_BACK,   32'h0);
    send_cmd(MODE_REVERSE,    32'h0);
    send_cmd(MODE_POP_FRONT,  32'h0);

    // churn near empty, fill to full depth, then churn at the full boundary
    run_random(60, 45, 40, 8, 1'b0);
    run_random(0, 97, 1, 1, 1'b1);
    run_random(60, 45, 40, 10, 1'b0);

    cmd.valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (pending != 0) $display("responses never delivered: %0d", pending);

    $display("sent %0d pushes, %0d pops, %0d reverses and %0d spare codes",
             n_push, n_pop, n_rev, n_spare);
    $display("checked %0d responses, %0d of them empty pops and %0d dropped pushes",
             checked, empty_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> deque_with_reverse.f
rtl/dqr_pkg.sv
rtl/dqr_cmd_if.sv
rtl/dqr_rsp_if.sv
rtl/dqr_ram.sv
rtl/dqr_ctrl.sv
rtl/dqr_dp.sv
rtl/deque_with_reverse.sv
tb/sv/dqr_checker.sv
tb/sv/tb.sv
